// File: src/mm4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants and types for the Q16.16 square matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

   localparam int DIM      = 4;
   localparam int ELEMS    = DIM * DIM;
   localparam int FRAC     = 16;
   localparam int DATA_W   = 32;
   localparam int K_W      = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int CNT_W    = (ELEMS > 1) ? $clog2(ELEMS) : 1;
   localparam int ACC_W    = 2 * DATA_W + K_W;
   // top accumulator bits that must agree for the shifted sum to fit
   localparam int SAT_HI_W = ACC_W - FRAC - DATA_W + 1;

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic [2:0]               idx_type;
   typedef logic [K_W-1:0]           kidx_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef struct packed {
      elem_type left_element;
      elem_type right_element;
   } req_payload_type;

   typedef struct packed {
      elem_type product_element;
      idx_type  element_row;
      idx_type  element_col;
      logic     was_saturated;
      logic     last_element;
   } rsp_payload_type;

   // one left element travelling down the cell chain
   typedef struct packed {
      logic     valid;
      elem_type a;
      kidx_type k;
      logic     last;
   } feed_type;

   // right element write into the column stores
   typedef struct packed {
      logic     en;
      kidx_type k;
      kidx_type col;
      elem_type data;
   } wr_type;

   typedef struct packed {
      logic    done;
      acc_type acc;
   } cell_stat_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_WAIT,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// File: src/mm4_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_req_if
// Valid/ready channel carrying one left and one right element per beat.
// ----------------------------------------------------------------------------
interface mm4_req_if;
   logic                     valid;
   logic                     ready;
   mm4_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/mm4_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_rsp_if
// Valid/ready channel carrying one product element per beat.
// ----------------------------------------------------------------------------
interface mm4_rsp_if;
   logic                     valid;
   logic                     ready;
   mm4_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/mm4_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_cell
// One column cell: holds a column of the right matrix, multiplies each
// passing left element by it and accumulates the dot product.
// ----------------------------------------------------------------------------
module mm4_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mm4_pkg::kidx_type      cell_index,
   input  wire mm4_pkg::wr_type        wr,
   input  wire logic                   clear,
   input  wire mm4_pkg::feed_type      feed_in,
   output mm4_pkg::feed_type           feed_out,
   output mm4_pkg::cell_stat_type      stat
);

   mm4_pkg::elem_type              col_ff [mm4_pkg::DIM];
   mm4_pkg::feed_type              feed_ff;
   logic signed [2*mm4_pkg::DATA_W-1:0] prod_ff;
   logic                           prod_valid_ff;
   logic                           prod_first_ff;
   logic                           prod_last_ff;
   mm4_pkg::acc_type               acc_ff;
   logic                           done_ff;
   mm4_pkg::elem_type              b_sel;

   assign b_sel = col_ff[feed_in.k];

   always_ff @(posedge clock) begin
      if (wr.en && wr.col == cell_index) begin
         col_ff[wr.k] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_ff       <= '0;
         prod_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         feed_ff       <= feed_in;
         prod_valid_ff <= feed_in.valid;
         if (clear) begin
            done_ff <= 1'b0;
         end else if (prod_valid_ff && prod_last_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= feed_in.a * b_sel;
      prod_first_ff <= (feed_in.k == '0);
      prod_last_ff  <= feed_in.last;
      if (prod_valid_ff) begin
         if (prod_first_ff) begin
            acc_ff <= mm4_pkg::acc_type'(prod_ff);
         end else begin
            acc_ff <= acc_ff + mm4_pkg::acc_type'(prod_ff);
         end
      end
   end

   assign feed_out  = feed_ff;
   assign stat.done = done_ff;
   assign stat.acc  = acc_ff;

endmodule
`default_nettype wire

// File: src/matrix4_multiply_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_multiply_core
// Square matrix product C = A * B in Q16.16 fixed point.
//
// req_chan takes one beat per element pair (A and B, row-major). After the
// last pair of a matrix, rsp_chan returns every element of C in row-major
// order with its row and column, a saturation flag and a last-element mark.
// Each element is floor(sum A[r][k]*B[k][c] / 2^16) clipped to 32-bit signed.
// A chain of DIM column cells holds B; each row of A is read from the left
// store one element a cycle and travels down the chain, every cell doing one
// multiply-accumulate per cycle.
// Loading accepts one beat per cycle while req_chan.valid is high. Each row
// of C is then issued, run down the chain and sent as DIM output beats,
// while req_chan.ready stays low from the last pair until the final
// element of C has been loaded into the output register.
// Reset clears the load position and all control state; stores need no
// clearing. When rsp_chan.ready is low the output beat holds and the row
// drain waits; nothing is dropped.
// ----------------------------------------------------------------------------
module matrix4_multiply_core (
   input  wire logic  clock,
   input  wire logic  reset,
   mm4_req_if.sink    req_chan,
   mm4_rsp_if.source  rsp_chan
);

   mm4_pkg::state_type       state_ff, state_in;
   logic [mm4_pkg::CNT_W-1:0] ld_cnt_ff;
   mm4_pkg::kidx_type        ld_row_ff, ld_col_ff;
   logic [mm4_pkg::CNT_W-1:0] iss_addr_ff;
   mm4_pkg::kidx_type        iss_k_ff;
   mm4_pkg::kidx_type        row_ff;
   mm4_pkg::kidx_type        col_ff;
   mm4_pkg::elem_type        left_mem [mm4_pkg::ELEMS];
   mm4_pkg::elem_type        left_rd_ff;
   logic                     rd_valid_ff;
   mm4_pkg::kidx_type        rd_k_ff;
   logic                     rd_last_ff;
   logic                     rsp_valid_ff;
   mm4_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   mm4_pkg::feed_type        feed [mm4_pkg::DIM+1];
   mm4_pkg::cell_stat_type   stat [mm4_pkg::DIM];
   mm4_pkg::wr_type          wr;

   logic                     req_beat;
   logic                     load_last;
   logic                     issuing;
   logic                     issue_last;
   logic                     clear;
   logic                     out_load;
   logic                     col_last;
   logic                     row_last;
   mm4_pkg::acc_type         sel_acc;
   logic [mm4_pkg::SAT_HI_W-1:0] sat_hi;
   logic                     fits;

   assign req_chan.ready = (state_ff == mm4_pkg::ST_LOAD);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign load_last      = (ld_row_ff == mm4_pkg::kidx_type'(mm4_pkg::DIM - 1)) &&
                           (ld_col_ff == mm4_pkg::kidx_type'(mm4_pkg::DIM - 1));
   assign issue_last     = (iss_k_ff == mm4_pkg::kidx_type'(mm4_pkg::DIM - 1));
   assign col_last       = (col_ff == mm4_pkg::kidx_type'(mm4_pkg::DIM - 1));
   assign row_last       = (row_ff == mm4_pkg::kidx_type'(mm4_pkg::DIM - 1));

   assign wr.en   = req_beat;
   assign wr.k    = ld_row_ff;
   assign wr.col  = ld_col_ff;
   assign wr.data = req_chan.payload.right_element;

   // left store
   always_ff @(posedge clock) begin
      if (req_beat) begin
         left_mem[ld_cnt_ff] <= req_chan.payload.left_element;
      end
      left_rd_ff <= left_mem[iss_addr_ff];
   end

   // head of the cell chain, aligned with the registered store read
   assign feed[0].valid = rd_valid_ff;
   assign feed[0].a     = left_rd_ff;
   assign feed[0].k     = rd_k_ff;
   assign feed[0].last  = rd_last_ff;

   for (genvar g = 0; g < mm4_pkg::DIM; g++) begin : g_cell
      mm4_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (mm4_pkg::kidx_type'(g)),
         .wr         (wr),
         .clear      (clear),
         .feed_in    (feed[g]),
         .feed_out   (feed[g+1]),
         .stat       (stat[g])
      );
   end

   // floor shift and saturation of the selected column
   assign sel_acc = stat[col_ff].acc;
   assign sat_hi  = sel_acc[mm4_pkg::ACC_W-1:mm4_pkg::FRAC+mm4_pkg::DATA_W-1];
   assign fits    = (sat_hi == '0) || (sat_hi == '1);

   always_comb begin
      rsp_data_in.element_row   = mm4_pkg::idx_type'(row_ff);
      rsp_data_in.element_col   = mm4_pkg::idx_type'(col_ff);
      rsp_data_in.was_saturated = !fits;
      rsp_data_in.last_element  = row_last && col_last;
      if (fits) begin
         rsp_data_in.product_element =
            sel_acc[mm4_pkg::FRAC+mm4_pkg::DATA_W-1:mm4_pkg::FRAC];
      end else if (sel_acc[mm4_pkg::ACC_W-1]) begin
         rsp_data_in.product_element = {1'b1, {(mm4_pkg::DATA_W-1){1'b0}}};
      end else begin
         rsp_data_in.product_element = {1'b0, {(mm4_pkg::DATA_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in = state_ff;
      issuing  = 1'b0;
      clear    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         mm4_pkg::ST_LOAD: begin
            if (req_beat && load_last) begin
               state_in = mm4_pkg::ST_ISSUE;
            end
         end
         mm4_pkg::ST_ISSUE: begin
            issuing = 1'b1;
            clear   = (iss_k_ff == '0);
            if (issue_last) begin
               state_in = mm4_pkg::ST_WAIT;
            end
         end
         mm4_pkg::ST_WAIT: begin
            if (stat[mm4_pkg::DIM-1].done) begin
               state_in = mm4_pkg::ST_EMIT;
            end
         end
         mm4_pkg::ST_EMIT: begin
            out_load = !rsp_valid_ff || rsp_chan.ready;
            if (out_load && col_last) begin
               state_in = row_last ? mm4_pkg::ST_LOAD : mm4_pkg::ST_ISSUE;
            end
         end
         default: begin
            state_in = mm4_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm4_pkg::ST_LOAD;
         ld_cnt_ff    <= '0;
         ld_row_ff    <= '0;
         ld_col_ff    <= '0;
         iss_addr_ff  <= '0;
         iss_k_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rd_k_ff      <= '0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issuing;
         rd_k_ff     <= iss_k_ff;
         rd_last_ff  <= issue_last;

         if (req_beat) begin
            if (load_last) begin
               ld_cnt_ff <= '0;
               ld_row_ff <= '0;
               ld_col_ff <= '0;
            end else if (ld_col_ff == mm4_pkg::kidx_type'(mm4_pkg::DIM - 1)) begin
               ld_cnt_ff <= ld_cnt_ff + 1'b1;
               ld_row_ff <= ld_row_ff + 1'b1;
               ld_col_ff <= '0;
            end else begin
               ld_cnt_ff <= ld_cnt_ff + 1'b1;
               ld_col_ff <= ld_col_ff + 1'b1;
            end
         end

         if (state_ff == mm4_pkg::ST_LOAD) begin
            iss_addr_ff <= '0;
            iss_k_ff    <= '0;
            row_ff      <= '0;
            col_ff      <= '0;
         end else if (issuing) begin
            iss_addr_ff <= iss_addr_ff + 1'b1;
            iss_k_ff    <= issue_last ? '0 : iss_k_ff + 1'b1;
         end else if (out_load) begin
            if (col_last) begin
               col_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix4_multiply_core. Pairs of left and right
// elements go in on req_chan with random gaps. Products come back on rsp_chan
// under random backpressure. A directed table runs first: a matrix whose
// products are known by hand covers both clip bounds, zero and a small
// result. Random matrices in several value ranges follow. Every product beat
// is checked against the hand value or a floor-and-clip model of C = A * B.
// ----------------------------------------------------------------------------
module tb;

   localparam int  DIRECTED_ROWS = 25;
   localparam int  TOTAL_PAIRS   = 432;
   localparam int  DRAIN_CYCLES  = 200;
   localparam longint CYCLE_LIMIT = 600000;

   localparam mm4_pkg::elem_type MOST_NEG  = 32'sh8000_0000;
   localparam mm4_pkg::elem_type MOST_POS  = 32'sh7fff_ffff;
   localparam mm4_pkg::elem_type ONE       = 32'sh0001_0000;
   localparam mm4_pkg::elem_type MINUS_LSB = 32'shffff_ffff;

   localparam logic signed [65:0] CLIP_HIGH = 66'sd2147483647;
   localparam logic signed [65:0] CLIP_LOW  = -66'sd2147483648;

   typedef enum int {
      RANGE_FULL,
      RANGE_SMALL,
      RANGE_EDGE,
      RANGE_BOUNDARY
   } value_range_type;

   typedef struct packed {
      mm4_pkg::elem_type left;
      mm4_pkg::elem_type right;
      logic              known;
      mm4_pkg::elem_type product;
      logic              clipped;
   } directed_row_type;

   // first matrix: A rows are min, max, zero, minus one lsb; B is all min
   directed_row_type stim_table [DIRECTED_ROWS] = '{
      '{MOST_NEG,  MOST_NEG, 1'b1, MOST_POS,       1'b1},
      '{MOST_NEG,  MOST_NEG, 1'b1, MOST_POS,       1'b1},
      '{MOST_NEG,  MOST_NEG, 1'b1, MOST_POS,       1'b1},
      '{MOST_NEG,  MOST_NEG, 1'b1, MOST_POS,       1'b1},
      '{MOST_POS,  MOST_NEG, 1'b1, MOST_NEG,       1'b1},
      '{MOST_POS,  MOST_NEG, 1'b1, MOST_NEG,       1'b1},
      '{MOST_POS,  MOST_NEG, 1'b1, MOST_NEG,       1'b1},
      '{MOST_POS,  MOST_NEG, 1'b1, MOST_NEG,       1'b1},
      '{32'sd0,    MOST_NEG, 1'b1, 32'sd0,         1'b0},
      '{32'sd0,    MOST_NEG, 1'b1, 32'sd0,         1'b0},
      '{32'sd0,    MOST_NEG, 1'b1, 32'sd0,         1'b0},
      '{32'sd0,    MOST_NEG, 1'b1, 32'sd0,         1'b0},
      '{MINUS_LSB, MOST_NEG, 1'b1, 32'sh0002_0000, 1'b0},
      '{MINUS_LSB, MOST_NEG, 1'b1, 32'sh0002_0000, 1'b0},
      '{MINUS_LSB, MOST_NEG, 1'b1, 32'sh0002_0000, 1'b0},
      '{MINUS_LSB, MOST_NEG, 1'b1, 32'sh0002_0000, 1'b0},
      '{ONE,            ONE,            1'b0, 32'sd0, 1'b0},
      '{MOST_POS,       MOST_POS,       1'b0, 32'sd0, 1'b0},
      '{32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, 32'sd0, 1'b0},
      '{-ONE,           ONE,            1'b0, 32'sd0, 1'b0},
      '{32'sh0000_8000, 32'shffff_8000, 1'b0, 32'sd0, 1'b0},
      '{32'sd1,         MINUS_LSB,      1'b0, 32'sd0, 1'b0},
      '{32'sh7fff_0000, 32'sh0002_0000, 1'b0, 32'sd0, 1'b0},
      '{MOST_NEG,       MOST_POS,       1'b0, 32'sd0, 1'b0},
      '{32'sh1234_5678, 32'shedcb_a988, 1'b0, 32'sd0, 1'b0}
   };

   logic clock;
   logic reset;

   mm4_req_if req_chan ();
   mm4_rsp_if rsp_chan ();

   matrix4_multiply_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mm4_pkg::elem_type left_mat    [mm4_pkg::ELEMS];
   mm4_pkg::elem_type right_mat   [mm4_pkg::ELEMS];
   logic              known_mat   [mm4_pkg::ELEMS];
   mm4_pkg::elem_type known_value [mm4_pkg::ELEMS];
   logic              known_clip  [mm4_pkg::ELEMS];
   int                load_pos;

   mm4_pkg::rsp_payload_type pending_products [$];

   int     pairs_loaded;
   int     matrices_done;
   int     beats_checked;
   int     clipped_seen;
   int     error_count;
   longint cycle_count;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // store one pair; on the last pair of a matrix queue every product
   task automatic load_pair(input mm4_pkg::elem_type left, input mm4_pkg::elem_type right,
                            input logic known, input mm4_pkg::elem_type product,
                            input logic clipped);
      logic signed [65:0]       acc;
      logic signed [65:0]       wide_a;
      logic signed [65:0]       wide_b;
      logic signed [65:0]       scaled;
      mm4_pkg::rsp_payload_type want;
      int                       idx;
      left_mat[load_pos]    = left;
      right_mat[load_pos]   = right;
      known_mat[load_pos]   = known;
      known_value[load_pos] = product;
      known_clip[load_pos]  = clipped;
      pairs_loaded++;
      load_pos++;
      if (load_pos == mm4_pkg::ELEMS) begin
         load_pos = 0;
         matrices_done++;
         for (int r = 0; r < mm4_pkg::DIM; r++) begin
            for (int c = 0; c < mm4_pkg::DIM; c++) begin
               idx = r * mm4_pkg::DIM + c;
               acc = '0;
               for (int k = 0; k < mm4_pkg::DIM; k++) begin
                  wide_a = left_mat[r * mm4_pkg::DIM + k];
                  wide_b = right_mat[k * mm4_pkg::DIM + c];
                  acc    = acc + wide_a * wide_b;
               end
               scaled = acc >>> mm4_pkg::FRAC;
               if (scaled > CLIP_HIGH) begin
                  want.product_element = MOST_POS;
                  want.was_saturated   = 1'b1;
               end else if (scaled < CLIP_LOW) begin
                  want.product_element = MOST_NEG;
                  want.was_saturated   = 1'b1;
               end else begin
                  want.product_element = scaled[mm4_pkg::DATA_W-1:0];
                  want.was_saturated   = 1'b0;
               end
               if (known_mat[idx]) begin
                  want.product_element = known_value[idx];
                  want.was_saturated   = known_clip[idx];
               end
               want.element_row  = mm4_pkg::idx_type'(r);
               want.element_col  = mm4_pkg::idx_type'(c);
               want.last_element = (r == mm4_pkg::DIM - 1) && (c == mm4_pkg::DIM - 1);
               pending_products.push_back(want);
            end
         end
      end
   endtask

   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic mm4_pkg::elem_type random_element(input value_range_type span);
      case (span)
         RANGE_SMALL:    return $signed($urandom) >>> $urandom_range(8, 14);
         RANGE_BOUNDARY: return $signed($urandom) >>> $urandom_range(8, 10);
         RANGE_EDGE: begin
            case ($urandom_range(0, 6))
               0:       return MOST_NEG;
               1:       return MOST_POS;
               2:       return 32'sd0;
               3:       return MINUS_LSB;
               4:       return 32'sd1;
               5:       return ONE;
               default: return -ONE;
            endcase
         end
         default:        return $urandom;
      endcase
   endfunction

   task automatic send_pair(input mm4_pkg::elem_type left, input mm4_pkg::elem_type right,
                            input bit quiet, input logic known,
                            input mm4_pkg::elem_type product, input logic clipped);
      int gap;
      gap = pick_gap(quiet);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= {left, right};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      load_pair(left, right, known, product, clipped);
   endtask

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   // result side: compare each product beat with the oldest expectation
   always @(posedge clock) begin : product_check
      mm4_pkg::rsp_payload_type want;
      mm4_pkg::rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (pending_products.size() == 0) begin
            $error("product beat with nothing expected: row %0d col %0d value %0d",
                   got.element_row, got.element_col, got.product_element);
            error_count++;
         end else begin
            want = pending_products.pop_front();
            check_field("product_element", want.product_element, got.product_element);
            check_field("element_row", want.element_row, got.element_row);
            check_field("element_col", want.element_col, got.element_col);
            check_field("was_saturated", want.was_saturated, got.was_saturated);
            check_field("last_element", want.last_element, got.last_element);
            beats_checked++;
            if (want.was_saturated)
               clipped_seen++;
         end
      end
   end

   // backpressure: bursts of ready with random stalls in between
   initial begin : rsp_backpressure
      int stall;
      int burst;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = pick_gap($urandom_range(0, 4) == 0);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         repeat (burst) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timed out, %0d products still pending", pending_products.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      value_range_type span;
      bit              quiet;
      int              roll;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      load_pos      = 0;
      pairs_loaded  = 0;
      matrices_done = 0;
      beats_checked = 0;
      clipped_seen  = 0;
      error_count   = 0;
      cycle_count   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_pair(stim_table[i].left, stim_table[i].right, i < 8, stim_table[i].known,
                   stim_table[i].product, stim_table[i].clipped);

      span  = RANGE_FULL;
      quiet = 1'b0;
      while (pairs_loaded < TOTAL_PAIRS) begin
         if (load_pos == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
               span = RANGE_FULL;
            else if (roll < 55)
               span = RANGE_SMALL;
            else if (roll < 70)
               span = RANGE_EDGE;
            else
               span = RANGE_BOUNDARY;
            quiet = ($urandom_range(0, 3) == 0);
         end
         send_pair(random_element(span), random_element(span), quiet, 1'b0, '0, 1'b0);
      end
      req_chan.valid <= 1'b0;

      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d pairs loaded, %0d matrices multiplied", pairs_loaded, matrices_done);
      $display("tb: %0d product beats checked, %0d of them clipped", beats_checked,
               clipped_seen);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// File: files.f
src/mm4_pkg.sv
src/mm4_req_if.sv
src/mm4_rsp_if.sv
src/mm4_cell.sv
src/matrix4_multiply_core.sv
tb/tb.sv
